/* hw/rtl/sca_pkg.sv */
// sca_pkg: shared constants, codes and types for the chunked slot allocator.
// No dependencies; imported by every module of the block.
package sca_pkg;

    // default geometry
    localparam int DEF_SLOTS_PER_CHUNK = 64;
    localparam int DEF_MAX_CHUNKS      = 8;

    // configuration register
    localparam int             EPC_W      = 7;
    localparam logic [EPC_W-1:0] EPC_RESET = 7'd64;
    localparam int             APB_ADDR_W = 3;
    localparam int             APB_DATA_W = 32;
    localparam logic [0:0]     REG_EPC    = 1'b0;  // register index (paddr[2])

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam int              STATUS_W    = 2;
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // update request into the chunk table
    typedef struct packed {
        logic pop;   // slot taken from the chunk
        logic push;  // slot returned to the chunk
        logic open;  // chunk is newly opened
    } tbl_op_t;

endpackage

/* hw/rtl/chunked_slot_allocator.sv */
// chunked_slot_allocator: top level of the fixed-size slot pool allocator.
// Depends on sca_pkg, sca_stack_mem, sca_mark_mem, sca_chunk_tbl.
//
// Usage
//   Command channel (s_*): s_cmd = CMD_ALLOC takes a slot; s_cmd = CMD_FREE with
//   s_has_handle returns s_free_handle (chunk * SLOTS_PER_CHUNK + slot). A free
//   with s_has_handle low is a null free and only gets an OK response.
//   Response channel (m_*): exactly one transfer per command, in order, carrying
//   m_status and m_alloc_handle (zero unless an allocate succeeded).
//   APB port: one register, elements_per_chunk at byte address 0 (0 acts as 1,
//   values above SLOTS_PER_CHUNK act as SLOTS_PER_CHUNK). Write it only while idle.
// Timing
//   One command at a time. A command with memory work (allocate, free of a live
//   handle) goes from accept to response through look-up and RAM read, RAM
//   read-modify-write, response load, back to idle. Null free, pool full and
//   out-of-range free skip the RAM write. The bound is the single read-modify-write
//   pass through the stack and mark RAMs per command.
// Reset
//   Synchronous, active low. After reset chunk 0 is open with all slots free,
//   counts are zero and no RAM clearing pass is needed: unpushed stack entries
//   are recognized by a per-chunk high-water count, and mark rows read as zero
//   until first written.
// Backpressure
//   The response sits in an output register; while m_ready is low the next
//   command is still accepted and worked, and waits only to load its response.
module chunked_slot_allocator
    import sca_pkg::*;
#(
    parameter int SLOTS_PER_CHUNK = DEF_SLOTS_PER_CHUNK,
    parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
    localparam int HANDLE_W = (MAX_CHUNKS * SLOTS_PER_CHUNK > 1) ?
                              $clog2(MAX_CHUNKS * SLOTS_PER_CHUNK) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // command channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic                  s_has_handle,
    input  logic [HANDLE_W-1:0]   s_free_handle,
    // response channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [HANDLE_W-1:0]   m_alloc_handle,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CH_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W  = $clog2(SLOTS_PER_CHUNK + 1);
    localparam int OPEN_W = $clog2(MAX_CHUNKS + 1);
    localparam int SLOT_W = (SLOTS_PER_CHUNK > 1) ? $clog2(SLOTS_PER_CHUNK) : 1;
    localparam int POOL   = MAX_CHUNKS * SLOTS_PER_CHUNK;
    localparam int POOL_W = (POOL > 1) ? $clog2(POOL) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a command
    localparam logic [1:0] S_LOOK = 2'd1;  // pick chunk, issue RAM reads
    localparam logic [1:0] S_UPD  = 2'd2;  // modify and write back
    localparam logic [1:0] S_RESP = 2'd3;  // load response register

    logic [1:0] state_reg, state_next;

    // configuration
    logic [EPC_W-1:0] epc_reg;
    logic [CNT_W-1:0] limit;

    // command held for the duration of the operation
    logic                cmd_reg;
    logic                has_reg;
    logic [HANDLE_W-1:0] fh_reg;

    // operation context captured in S_LOOK
    logic [CH_W-1:0]     chunk_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                fill_reg;      // stack entry was pushed, read it from RAM
    logic                open_flag_reg; // allocate opens a new chunk
    logic [SLOT_W-1:0]   slot_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [HANDLE_W-1:0] res_handle_reg;

    // response register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [HANDLE_W-1:0] m_alloc_handle_reg;
    logic                out_free;

    // chunk table
    tbl_op_t           tbl_op;
    logic [CNT_W-1:0]  q_count;
    logic              pick_found;
    logic [CH_W-1:0]   pick_chunk;
    logic [CNT_W-1:0]  pick_count;
    logic [CNT_W-1:0]  pick_hw;
    logic [OPEN_W-1:0] open_cnt;
    logic              can_open;

    // RAM ports
    logic                       sm_rd_en, sm_wr_en;
    logic [POOL_W-1:0]          sm_rd_addr, sm_wr_addr;
    logic [SLOT_W-1:0]          sm_rd_data, sm_wr_data;
    logic                       mk_rd_en, mk_wr_en;
    logic [CH_W-1:0]            mk_rd_row;
    logic [SLOTS_PER_CHUNK-1:0] mk_rd_data, mk_wr_data;

    // look-up stage
    logic [CH_W-1:0]     a_chunk;
    logic [CNT_W-1:0]    a_count;
    logic [CNT_W-1:0]    a_hw;
    logic [OPEN_W-1:0]   f_chunk;
    logic [SLOT_W-1:0]   f_slot;
    logic [CH_W-1:0]     look_chunk;
    logic [STATUS_W-1:0] look_status;
    logic                look_go_upd;

    // update stage
    logic [SLOT_W-1:0]   a_slot;
    logic                free_ok;
    logic [STATUS_W-1:0] upd_status;
    logic [HANDLE_W-1:0] upd_handle;

    //------------------------------------------------------------------
    // APB register
    //------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epc_reg <= EPC_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1:2] == REG_EPC)) begin
            epc_reg <= pwdata[EPC_W-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_EPC) ? APB_DATA_W'(epc_reg) : '0;

    // effective per-chunk limit, clamped to 1..SLOTS_PER_CHUNK
    always_comb begin
        if (epc_reg == '0) begin
            limit = CNT_W'(1);
        end else if (int'(epc_reg) > SLOTS_PER_CHUNK) begin
            limit = CNT_W'(SLOTS_PER_CHUNK);
        end else begin
            limit = CNT_W'(epc_reg);
        end
    end

    //------------------------------------------------------------------
    // Look-up: chunk choice for allocate, handle split for free
    //------------------------------------------------------------------
    assign a_chunk = pick_found ? pick_chunk : CH_W'(open_cnt);
    assign a_count = pick_found ? pick_count : '0;
    assign a_hw    = pick_found ? pick_hw    : '0;

    // handle -> chunk by parallel compares against chunk boundaries
    always_comb begin
        int f_base;
        f_chunk = '0;
        f_base  = 0;
        for (int k = 1; k <= MAX_CHUNKS; k++) begin
            if (int'(fh_reg) >= k * SLOTS_PER_CHUNK) begin
                f_chunk = OPEN_W'(k);
                f_base  = k * SLOTS_PER_CHUNK;
            end
        end
        f_slot = SLOT_W'(int'(fh_reg) - f_base);
    end

    always_comb begin
        look_chunk  = CH_W'(f_chunk);
        look_status = ST_OK;
        look_go_upd = 1'b0;
        sm_rd_en    = 1'b0;
        mk_rd_en    = 1'b0;
        if (state_reg == S_LOOK) begin
            if (cmd_reg == CMD_ALLOC) begin
                look_chunk = a_chunk;
                if (pick_found || can_open) begin
                    look_go_upd = 1'b1;
                    sm_rd_en    = 1'b1;
                    mk_rd_en    = 1'b1;
                end else begin
                    look_status = ST_FULL;
                end
            end else if (has_reg) begin
                if (f_chunk < open_cnt) begin
                    look_go_upd = 1'b1;
                    mk_rd_en    = 1'b1;
                end else begin
                    look_status = ST_BAD_FREE;
                end
            end
        end
    end

    assign sm_rd_addr = POOL_W'(int'(a_chunk) * SLOTS_PER_CHUNK + int'(a_count));
    assign mk_rd_row  = look_chunk;

    //------------------------------------------------------------------
    // Update: pop/push, mark write-back
    //------------------------------------------------------------------
    // a stack entry never pushed since reset still holds its own position
    assign a_slot  = fill_reg ? sm_rd_data : count_reg[SLOT_W-1:0];
    assign free_ok = mk_rd_data[slot_reg] && (q_count != '0);

    always_comb begin
        tbl_op     = '0;
        sm_wr_en   = 1'b0;
        mk_wr_en   = 1'b0;
        mk_wr_data = mk_rd_data;
        upd_status = ST_OK;
        upd_handle = '0;
        if (state_reg == S_UPD) begin
            if (cmd_reg == CMD_ALLOC) begin
                tbl_op.pop  = 1'b1;
                tbl_op.open = open_flag_reg;
                mk_wr_en    = 1'b1;
                mk_wr_data  = mk_rd_data | (SLOTS_PER_CHUNK'(1) << a_slot);
                upd_handle  = HANDLE_W'(int'(chunk_reg) * SLOTS_PER_CHUNK + int'(a_slot));
            end else if (free_ok) begin
                tbl_op.push = 1'b1;
                sm_wr_en    = 1'b1;
                mk_wr_en    = 1'b1;
                mk_wr_data  = mk_rd_data & ~(SLOTS_PER_CHUNK'(1) << slot_reg);
            end else begin
                upd_status = ST_BAD_FREE;
            end
        end
    end

    assign sm_wr_addr = POOL_W'(int'(chunk_reg) * SLOTS_PER_CHUNK + int'(q_count) - 1);
    assign sm_wr_data = slot_reg;

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                state_next = look_go_upd ? S_UPD : S_RESP;
            end
            S_UPD: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // operation context (payload, no reset)
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_reg <= s_cmd;
                    has_reg <= s_has_handle;
                    fh_reg  <= s_free_handle;
                end
            end
            S_LOOK: begin
                chunk_reg      <= look_chunk;
                count_reg      <= a_count;
                fill_reg       <= a_count < a_hw;
                open_flag_reg  <= !pick_found;
                slot_reg       <= f_slot;
                res_status_reg <= look_status;
                res_handle_reg <= '0;
            end
            S_UPD: begin
                res_status_reg <= upd_status;
                res_handle_reg <= upd_handle;
            end
            default: begin
            end
        endcase
    end

    // response register: the transfer is held until m_ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_RESP) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_RESP) && out_free) begin
            m_status_reg       <= res_status_reg;
            m_alloc_handle_reg <= res_handle_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_alloc_handle = m_alloc_handle_reg;

    //------------------------------------------------------------------
    // Storage
    //------------------------------------------------------------------
    sca_chunk_tbl #(
        .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK),
        .MAX_CHUNKS      (MAX_CHUNKS)
    ) u_tbl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .limit      (limit),
        .upd_chunk  (chunk_reg),
        .upd_op     (tbl_op),
        .q_chunk    (chunk_reg),
        .q_count    (q_count),
        .pick_found (pick_found),
        .pick_chunk (pick_chunk),
        .pick_count (pick_count),
        .pick_hw    (pick_hw),
        .open_cnt   (open_cnt),
        .can_open   (can_open)
    );

    sca_stack_mem #(
        .DEPTH (POOL),
        .WIDTH (SLOT_W)
    ) u_stack (
        .aclk    (aclk),
        .rd_en   (sm_rd_en),
        .rd_addr (sm_rd_addr),
        .rd_data (sm_rd_data),
        .wr_en   (sm_wr_en),
        .wr_addr (sm_wr_addr),
        .wr_data (sm_wr_data)
    );

    sca_mark_mem #(
        .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK),
        .MAX_CHUNKS      (MAX_CHUNKS)
    ) u_marks (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mk_rd_en),
        .rd_row  (mk_rd_row),
        .rd_data (mk_rd_data),
        .wr_en   (mk_wr_en),
        .wr_row  (chunk_reg),
        .wr_data (mk_wr_data)
    );

endmodule

/* hw/rtl/sca_stack_mem.sv */
// sca_stack_mem: free-stack storage, one synchronous RAM with registered read data.
// Depends on sca_pkg for default sizes.
module sca_stack_mem
    import sca_pkg::*;
#(
    parameter int DEPTH  = DEF_SLOTS_PER_CHUNK * DEF_MAX_CHUNKS,
    parameter int WIDTH  = $clog2(DEF_SLOTS_PER_CHUNK),
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/sca_mark_mem.sv */
// sca_mark_mem: allocated marks, one row of slot bits per chunk, in a synchronous RAM.
// A row reads as zero until first written (row valid flops). Depends on sca_pkg.
module sca_mark_mem
    import sca_pkg::*;
#(
    parameter int SLOTS_PER_CHUNK = DEF_SLOTS_PER_CHUNK,
    parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
    localparam int CH_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [CH_W-1:0]            rd_row,
    output logic [SLOTS_PER_CHUNK-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [CH_W-1:0]            wr_row,
    input  logic [SLOTS_PER_CHUNK-1:0] wr_data
);

    logic [SLOTS_PER_CHUNK-1:0] mem [MAX_CHUNKS];
    logic [SLOTS_PER_CHUNK-1:0] rd_data_reg;
    logic [MAX_CHUNKS-1:0]      row_vld_reg;
    logic                       rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_row] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= row_vld_reg[rd_row];
            end
        end
    end

    // unwritten rows hold garbage from power-up; present them as all free
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/sca_chunk_tbl.sv */
// sca_chunk_tbl: per-chunk use counts, stack fill marks, open-chunk count, first-fit pick.
// Depends on sca_pkg (tbl_op_t).
module sca_chunk_tbl
    import sca_pkg::*;
#(
    parameter int SLOTS_PER_CHUNK = DEF_SLOTS_PER_CHUNK,
    parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
    localparam int CH_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
    localparam int CNT_W  = $clog2(SLOTS_PER_CHUNK + 1),
    localparam int OPEN_W = $clog2(MAX_CHUNKS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  limit,
    // update port
    input  logic [CH_W-1:0]   upd_chunk,
    input  tbl_op_t           upd_op,
    // lookup port
    input  logic [CH_W-1:0]   q_chunk,
    output logic [CNT_W-1:0]  q_count,
    // first-fit pick
    output logic              pick_found,
    output logic [CH_W-1:0]   pick_chunk,
    output logic [CNT_W-1:0]  pick_count,
    output logic [CNT_W-1:0]  pick_hw,
    output logic [OPEN_W-1:0] open_cnt,
    output logic              can_open
);

    logic [CNT_W-1:0]  cnt_reg [MAX_CHUNKS];
    // highest count ever reached: stack entries at or above it were never pushed
    logic [CNT_W-1:0]  hw_reg  [MAX_CHUNKS];
    logic [OPEN_W-1:0] open_reg;
    logic [CNT_W-1:0]  cnt_inc;

    always_comb begin
        pick_found = 1'b0;
        pick_chunk = '0;
        pick_count = '0;
        pick_hw    = '0;
        for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
            if ((OPEN_W'(i) < open_reg) && (cnt_reg[i] < limit)) begin
                pick_found = 1'b1;
                pick_chunk = CH_W'(i);
                pick_count = cnt_reg[i];
                pick_hw    = hw_reg[i];
            end
        end
    end

    assign q_count  = cnt_reg[q_chunk];
    assign open_cnt = open_reg;
    assign can_open = open_reg < OPEN_W'(MAX_CHUNKS);
    assign cnt_inc  = cnt_reg[upd_chunk] + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                cnt_reg[i] <= '0;
                hw_reg[i]  <= '0;
            end
            open_reg <= OPEN_W'(1);
        end else begin
            if (upd_op.pop) begin
                cnt_reg[upd_chunk] <= cnt_inc;
                if (cnt_inc > hw_reg[upd_chunk]) begin
                    hw_reg[upd_chunk] <= cnt_inc;
                end
            end else if (upd_op.push) begin
                cnt_reg[upd_chunk] <= cnt_reg[upd_chunk] - 1'b1;
            end
            if (upd_op.open) begin
                open_reg <= open_reg + 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/sca_checker.sv */
// sca_checker: port-level assertions for chunked_slot_allocator, bound to the top level.
// Depends on sca_pkg (status codes).
module sca_checker
    import sca_pkg::*;
#(
    parameter int HANDLE_W = $clog2(DEF_SLOTS_PER_CHUNK * DEF_MAX_CHUNKS)
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [HANDLE_W-1:0] m_alloc_handle
);

    // first cycle out of reset: no pending response, ready for a command
    a_reset_idle: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> (!m_valid && s_ready))
        else $error("not idle after reset");

    // one command at a time: busy right after a command transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted while busy");

    // failed commands never carry a handle
    a_err_no_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_alloc_handle == '0))
        else $error("handle on failed response");

    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("response dropped while stalled");

    a_resp_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_status) && $stable(m_alloc_handle)))
        else $error("response changed while stalled");

endmodule

bind chunked_slot_allocator sca_checker #(
    .HANDLE_W (HANDLE_W)
) u_sca_checker (.*);
